>>> rtl/slrs_pkg.sv
// Shared types and constants for the sorted line record store.
// No dependencies; every other file imports this package.
package slrs_pkg;

    localparam int STORE_BYTES_DEF    = 4096;
    localparam int MAX_TEXT_BYTES_DEF = 255;

    // record header: number low, number high, length
    localparam int HEADER_BYTES = 3;
    // end marker at the tail of the store
    localparam int MARKER_BYTES = 2;

    localparam int          CAP_W     = 13;
    localparam logic [12:0] CAP_RESET = 13'd4096;

    // register index of capacity_limit
    localparam logic [1:0] REG_CAP = 2'd0;

    // result status codes
    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_NONE   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // source of the data for a queued store write
    typedef enum logic [1:0] {
        WS_DATA,
        WS_STORE,
        WS_TEXT
    } t_wsrc;

    // queued store write, executed in the cycle after it is issued
    typedef struct packed {
        logic       en;
        t_wsrc      src;
        logic [7:0] data;
    } t_wr_req;

endpackage

>>> rtl/slrs_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
// Depends on slrs_pkg for the default depth STORE_BYTES_DEF.
module slrs_ram
    import slrs_pkg::*;
#(
    parameter int DEPTH = STORE_BYTES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/slrs_seq.sv
// Commit sequencer: buffers text, walks the record store, deletes, shifts, inserts.
// Depends on slrs_pkg and drives the two slrs_ram instances in the top level.
module slrs_seq
    import slrs_pkg::*;
#(
    parameter int STORE_BYTES    = STORE_BYTES_DEF,
    parameter int MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF,
    parameter int MA = $clog2(STORE_BYTES),
    parameter int TA = (MAX_TEXT_BYTES > 1) ? $clog2(MAX_TEXT_BYTES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CAP_W-1:0] i_cap,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [15:0]      i_line_number,
    input  logic [7:0]       i_text_byte,
    input  logic             i_byte_valid,
    input  logic             i_last_byte,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    output logic [12:0]      o_used_bytes,
    // record store port
    output logic             o_st_we,
    output logic [MA-1:0]    o_st_waddr,
    output logic [7:0]       o_st_wdata,
    output logic [MA-1:0]    o_st_raddr,
    input  logic [7:0]       i_st_rdata,
    // text buffer port
    output logic             o_tb_we,
    output logic [TA-1:0]    o_tb_waddr,
    output logic [7:0]       o_tb_wdata,
    output logic [TA-1:0]    o_tb_raddr,
    input  logic [7:0]       i_tb_rdata
);

    localparam int AW = MA + 1;
    localparam int CW = ((AW > CAP_W) ? AW : CAP_W) + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SA   = 4'd1;
    localparam logic [3:0] S_SB   = 4'd2;
    localparam logic [3:0] S_SC   = 4'd3;
    localparam logic [3:0] S_SD   = 4'd4;
    localparam logic [3:0] S_DEL  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_INS  = 4'd7;
    localparam logic [3:0] S_H0   = 4'd8;
    localparam logic [3:0] S_H1   = 4'd9;
    localparam logic [3:0] S_H2   = 4'd10;
    localparam logic [3:0] S_TXT  = 4'd11;
    localparam logic [3:0] S_RES  = 4'd12;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_src, n_src;
    logic [AW-1:0] r_used, n_used;
    logic [7:0]    r_len, n_len;
    logic [15:0]   r_num, n_num;
    logic [7:0]    r_lo, n_lo;
    logic [7:0]    r_hi, n_hi;
    logic [8:0]    r_size, n_size;
    logic [7:0]    r_j, n_j;
    logic [1:0]    r_stat, n_stat;
    t_wr_req       r_wr, n_wr;
    logic [MA-1:0] r_wa, n_wa;
    logic          r_ov, n_ov;
    logic [1:0]    r_os, n_os;
    logic [12:0]   r_ou, n_ou;

    logic          in_acc;
    logic [AW-1:0] rec_end;
    logic [AW-1:0] rd_size;
    logic [15:0]   rec_num;
    logic [CW-1:0] need;
    logic [CW-1:0] lim;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign rec_end    = r_used - AW'(MARKER_BYTES);
    assign rd_size    = AW'(i_st_rdata) + AW'(HEADER_BYTES);
    assign rec_num    = {r_hi, r_lo};
    assign need       = CW'(r_used) + CW'(r_len) + CW'(HEADER_BYTES);
    assign lim        = (CW'(i_cap) > CW'(STORE_BYTES)) ? CW'(STORE_BYTES) : CW'(i_cap);

    // queued store write executes here, in the cycle after its read address is issued
    always_comb begin
        o_st_we    = r_wr.en;
        o_st_waddr = r_wa;
        case (r_wr.src)
            WS_STORE: o_st_wdata = i_st_rdata;
            WS_TEXT:  o_st_wdata = i_tb_rdata;
            default:  o_st_wdata = r_wr.data;
        endcase
    end

    assign o_tb_wdata = i_text_byte;
    assign o_tb_waddr = TA'(r_len);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_src   = r_src;
        n_used  = r_used;
        n_len   = r_len;
        n_num   = r_num;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_size  = r_size;
        n_j     = r_j;
        n_stat  = r_stat;
        n_wr    = '{en: 1'b0, src: WS_DATA, data: 8'd0};
        n_wa    = r_wa;
        n_ov    = r_ov && !i_out_ready;
        n_os    = r_os;
        n_ou    = r_ou;
        o_st_raddr = MA'(r_pos);
        o_tb_raddr = TA'(r_j);
        o_tb_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_byte_valid && (r_len < 8'(MAX_TEXT_BYTES))) begin
                        o_tb_we = 1'b1;
                        n_len   = r_len + 8'd1;
                    end
                    if (i_last_byte) begin
                        n_num = i_line_number;
                        n_pos = '0;
                        if (i_line_number == 16'd0) begin
                            n_stat  = ST_NONE;
                            n_state = S_RES;
                        end else begin
                            n_state = S_SA;
                        end
                    end
                end
            end
            // walk: read number low, high and length of the record at pos
            S_SA: begin
                if (r_pos < rec_end) begin
                    o_st_raddr = MA'(r_pos);
                    n_state    = S_SB;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_SB: begin
                n_lo       = i_st_rdata;
                o_st_raddr = MA'(r_pos + AW'(1));
                n_state    = S_SC;
            end
            S_SC: begin
                n_hi       = i_st_rdata;
                o_st_raddr = MA'(r_pos + AW'(2));
                n_state    = S_SD;
            end
            S_SD: begin
                if (rec_num < r_num) begin
                    n_pos   = r_pos + rd_size;
                    n_state = S_SA;
                end else if (rec_num == r_num) begin
                    n_size  = 9'(i_st_rdata) + 9'(HEADER_BYTES);
                    n_src   = r_pos + rd_size;
                    n_state = S_DEL;
                end else begin
                    n_state = S_CHK;
                end
            end
            // close the gap, ascending copy
            S_DEL: begin
                if (r_src < r_used) begin
                    o_st_raddr = MA'(r_src);
                    n_wr       = '{en: 1'b1, src: WS_STORE, data: 8'd0};
                    n_wa       = MA'(r_src - AW'(r_size));
                    n_src      = r_src + AW'(1);
                end else begin
                    n_used  = r_used - AW'(r_size);
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (need >= lim) begin
                    n_stat  = ST_FULL;
                    n_state = S_RES;
                end else if (r_len == 8'd0) begin
                    n_stat  = ST_NONE;
                    n_state = S_RES;
                end else begin
                    n_src   = r_used - AW'(1);
                    n_size  = 9'(r_len) + 9'(HEADER_BYTES);
                    n_state = S_INS;
                end
            end
            // open the gap, descending copy
            S_INS: begin
                o_st_raddr = MA'(r_src);
                n_wr       = '{en: 1'b1, src: WS_STORE, data: 8'd0};
                n_wa       = MA'(r_src + AW'(r_size));
                if (r_src == r_pos) begin
                    n_state = S_H0;
                end else begin
                    n_src = r_src - AW'(1);
                end
            end
            S_H0: begin
                n_wr    = '{en: 1'b1, src: WS_DATA, data: r_num[7:0]};
                n_wa    = MA'(r_pos);
                n_state = S_H1;
            end
            S_H1: begin
                n_wr    = '{en: 1'b1, src: WS_DATA, data: r_num[15:8]};
                n_wa    = MA'(r_pos + AW'(1));
                n_state = S_H2;
            end
            S_H2: begin
                n_wr    = '{en: 1'b1, src: WS_DATA, data: r_len};
                n_wa    = MA'(r_pos + AW'(2));
                n_j     = 8'd0;
                n_state = S_TXT;
            end
            S_TXT: begin
                o_tb_raddr = TA'(r_j);
                n_wr       = '{en: 1'b1, src: WS_TEXT, data: 8'd0};
                n_wa       = MA'(r_pos + AW'(HEADER_BYTES) + AW'(r_j));
                if (r_j == r_len - 8'd1) begin
                    n_used  = r_used + AW'(r_size);
                    n_stat  = ST_STORED;
                    n_state = S_RES;
                end else begin
                    n_j = r_j + 8'd1;
                end
            end
            S_RES: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_os    = r_stat;
                    n_ou    = 13'(r_used);
                    n_len   = 8'd0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= AW'(MARKER_BYTES);
            r_len   <= 8'd0;
            r_wr    <= '{en: 1'b0, src: WS_DATA, data: 8'd0};
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_len   <= n_len;
            r_wr    <= n_wr;
            r_ov    <= n_ov;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_src  <= n_src;
        r_num  <= n_num;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_size <= n_size;
        r_j    <= n_j;
        r_stat <= n_stat;
        r_wa   <= n_wa;
        r_os   <= n_os;
        r_ou   <= n_ou;
    end

    assign o_out_valid  = r_ov;
    assign o_status     = r_os;
    assign o_used_bytes = r_ou;

    // checks
    a_used_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used >= AW'(MARKER_BYTES))
        else $error("store use below end marker size");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= 8'(MAX_TEXT_BYTES))
        else $error("text length above buffer depth");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_src >= r_pos))
        else $error("insert shift ran below the gap");

    a_no_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && $past(r_state == S_IDLE) |-> !r_wr.en)
        else $error("store write pending while idle");

endmodule

>>> rtl/sorted_line_record_store.sv
// Top level: APB register, record store RAM, text buffer RAM and sequencer.
// Depends on slrs_pkg, slrs_ram and slrs_seq.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------------
//  input    | in        | i_in_valid / o_in_ready    | line_number, text_byte, flags
//  result   | out       | o_out_valid / i_out_ready  | status, used_bytes
//  config   | in        | psel, penable, pready      | paddr, pwdata, prdata
//
// A text item without last_byte is taken while the sequencer is idle. A commit
// walks the store one record header at a time, then moves every byte behind the
// record one per cycle through the single store read port (delete and insert
// shift), and writes header and text one byte per cycle.
// Reset is synchronous; the store needs no clearing pass, its use count marks
// the end. Input stays ready while a result waits; a commit waits at its end.
module sorted_line_record_store
    import slrs_pkg::*;
#(
    parameter int STORE_BYTES    = STORE_BYTES_DEF,
    parameter int MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_line_number,
    input  logic [7:0]  i_text_byte,
    input  logic        i_byte_valid,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [12:0] o_used_bytes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MA = $clog2(STORE_BYTES);
    localparam int TA = (MAX_TEXT_BYTES > 1) ? $clog2(MAX_TEXT_BYTES) : 1;

    logic [CAP_W-1:0] r_cap;

    logic          st_we, tb_we;
    logic [MA-1:0] st_waddr, st_raddr;
    logic [TA-1:0] tb_waddr, tb_raddr;
    logic [7:0]    st_wdata, st_rdata, tb_wdata, tb_rdata;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_CAP)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end
    assign prdata = (paddr == REG_CAP) ? 32'(r_cap) : 32'd0;

    slrs_ram #(.DEPTH(STORE_BYTES), .AW(MA)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    slrs_ram #(.DEPTH(MAX_TEXT_BYTES), .AW(TA)) u_text (
        .i_clk   (i_clk),
        .i_we    (tb_we),
        .i_waddr (tb_waddr),
        .i_wdata (tb_wdata),
        .i_raddr (tb_raddr),
        .o_rdata (tb_rdata)
    );

    slrs_seq #(
        .STORE_BYTES    (STORE_BYTES),
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
        .MA             (MA),
        .TA             (TA)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cap         (r_cap),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_line_number (i_line_number),
        .i_text_byte   (i_text_byte),
        .i_byte_valid  (i_byte_valid),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_used_bytes  (o_used_bytes),
        .o_st_we       (st_we),
        .o_st_waddr    (st_waddr),
        .o_st_wdata    (st_wdata),
        .o_st_raddr    (st_raddr),
        .i_st_rdata    (st_rdata),
        .o_tb_we       (tb_we),
        .o_tb_waddr    (tb_waddr),
        .o_tb_wdata    (tb_wdata),
        .o_tb_raddr    (tb_raddr),
        .i_tb_rdata    (tb_rdata)
    );

endmodule

>>> tb/sorted_line_record_store_tb.sv
// Testbench for sorted_line_record_store: directed and random line edits
// checked against a behavioral model of the sorted record store.
// Depends on slrs_pkg and the RTL of sorted_line_record_store.
`timescale 1ns / 1ps

module sorted_line_record_store_tb
    import slrs_pkg::*;
;

    localparam int STORE_SZ   = 4096;
    localparam int TEXT_MAX   = 255;
    localparam int CYCLE_CAP  = 4000000;

    typedef struct packed {
        logic [15:0] number;
        logic [7:0]  data;
        logic        dvalid;
        logic        last;
    } t_line_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] used;
    } t_commit_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_line_number;
    logic [7:0]  i_text_byte;
    logic        i_byte_valid;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [12:0] o_used_bytes;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sorted_line_record_store dut (.*);

    // model state
    logic [7:0]  mdl_store [STORE_SZ];
    int          mdl_used;
    logic [7:0]  mdl_text [TEXT_MAX];
    int          mdl_text_len;
    int          mdl_limit;

    t_line_item     pending_items[$];
    t_commit_result expected_commits[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  n_errors;
    int  n_commits;
    int  n_full;
    int  cycle_count;
    bit  driving_done;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int rec_number(int pos);
        return int'(mdl_store[pos]) | (int'(mdl_store[pos + 1]) << 8);
    endfunction

    // line commit: delete, capacity check, insert
    function automatic t_commit_result commit_line(int num);
        t_commit_result r;
        int end_pos, pos, size, len, lim;
        r.used = mdl_used[12:0];
        if (num == 0) begin
            r.status = ST_NONE;
            return r;
        end
        end_pos = mdl_used - MARKER_BYTES;
        pos = 0;
        while (pos < end_pos && rec_number(pos) < num)
            pos += int'(mdl_store[pos + 2]) + HEADER_BYTES;
        if (pos < end_pos && rec_number(pos) == num) begin
            size = int'(mdl_store[pos + 2]) + HEADER_BYTES;
            for (int k = pos; k < mdl_used - size; k++)
                mdl_store[k] = mdl_store[k + size];
            mdl_used -= size;
        end
        len = mdl_text_len;
        lim = (mdl_limit > STORE_SZ) ? STORE_SZ : mdl_limit;
        r.used = mdl_used[12:0];
        if (mdl_used + len + HEADER_BYTES >= lim) begin
            r.status = ST_FULL;
            return r;
        end
        if (len == 0) begin
            r.status = ST_NONE;
            return r;
        end
        for (int k = mdl_used - 1; k >= pos; k--)
            mdl_store[k + len + HEADER_BYTES] = mdl_store[k];
        mdl_used += len + HEADER_BYTES;
        mdl_store[pos]     = num[7:0];
        mdl_store[pos + 1] = num[15:8];
        mdl_store[pos + 2] = len[7:0];
        for (int k = 0; k < len; k++)
            mdl_store[pos + HEADER_BYTES + k] = mdl_text[k];
        r.status = ST_STORED;
        r.used = mdl_used[12:0];
        return r;
    endfunction

    // apply one accepted transaction to the model
    task automatic predict_item(t_line_item it);
        t_commit_result r;
        if (it.dvalid && mdl_text_len < TEXT_MAX) begin
            mdl_text[mdl_text_len] = it.data;
            mdl_text_len++;
        end
        if (it.last) begin
            r = commit_line(int'(it.number));
            mdl_text_len = 0;
            expected_commits.push_back(r);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_item(pending_items.pop_front());
            end
            if ((!i_in_valid || o_in_ready) && pending_items.size() > 0 &&
                    !(i_in_valid && o_in_ready && pending_items.size() == 0)) begin
                if ($urandom_range(99) >= send_idle_pct) begin
                    i_in_valid    <= 1'b1;
                    i_line_number <= pending_items[0].number;
                    i_text_byte   <= pending_items[0].data;
                    i_byte_valid  <= pending_items[0].dvalid;
                    i_last_byte   <= pending_items[0].last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (i_in_valid && o_in_ready) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_commit_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_commits++;
            if (expected_commits.size() == 0) begin
                $error("unexpected result status=%0d used_bytes=%0d", o_status, o_used_bytes);
                n_errors++;
            end else begin
                exp_r = expected_commits.pop_front();
                if (exp_r.status == ST_FULL) n_full++;
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_status);
                    n_errors++;
                end
                if (o_used_bytes !== exp_r.used) begin
                    $error("used_bytes expected %0d actual %0d", exp_r.used, o_used_bytes);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_line_item mk_item(int num, int data, bit dv, bit last);
        t_line_item it;
        it.number = num[15:0];
        it.data   = data[7:0];
        it.dvalid = dv;
        it.last   = last;
        return it;
    endfunction

    // queue a full line of len bytes, with random flags noise
    task automatic queue_line(int num, int len);
        for (int k = 0; k < len; k++)
            pending_items.push_back(mk_item($urandom, $urandom, 1'b1, 1'b0));
        if ($urandom_range(3) == 0)
            pending_items.push_back(mk_item($urandom, $urandom, 1'b0, 1'b0));
        pending_items.push_back(mk_item(num, $urandom, 1'b0, 1'b1));
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_in_valid || expected_commits.size() > 0)
            @(posedge i_clk);
        // a commit may still be shifting the store
        repeat (12000) @(posedge i_clk);
    endtask

    task automatic write_limit(int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAP;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mdl_limit = value & 32'h1FFF;
    endtask

    // random part: mostly small line numbers so replacements happen
    task automatic queue_random(int n_items);
        int cnt, len, num;
        cnt = 0;
        while (cnt < n_items) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(200, 270) : $urandom_range(0, 8);
            num = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 40);
            if ($urandom_range(49) == 0) num = 0;
            queue_line(num, len);
            cnt += len + 1;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_line_number = '0;
        i_text_byte = '0;
        i_byte_valid = 1'b0;
        i_last_byte = 1'b0;
        i_out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        n_errors = 0;
        n_commits = 0;
        n_full = 0;
        cycle_count = 0;
        for (int k = 0; k < STORE_SZ; k++) mdl_store[k] = 8'h00;
        for (int k = 0; k < TEXT_MAX; k++) mdl_text[k] = 8'h00;
        mdl_used = MARKER_BYTES;
        mdl_text_len = 0;
        mdl_limit = CAP_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero bytes, deletes, line zero, long text
        pending_items.push_back(mk_item(16'hFFFF, 8'hFF, 1'b1, 1'b1));
        pending_items.push_back(mk_item(1, 8'h00, 1'b1, 1'b1));
        pending_items.push_back(mk_item(16'h8000, 8'h55, 1'b1, 1'b0));
        pending_items.push_back(mk_item(16'h8000, 8'hAA, 1'b1, 1'b1));
        pending_items.push_back(mk_item(1, 8'h12, 1'b0, 1'b1));
        pending_items.push_back(mk_item(0, 8'h34, 1'b1, 1'b1));
        pending_items.push_back(mk_item(16'h00FF, 8'h00, 1'b0, 1'b1));
        pending_items.push_back(mk_item(16'hFF00, 8'h7E, 1'b1, 1'b1));
        queue_line(300, 260);
        wait_drained();

        // tiny limits: refuse everything, delete answers full
        write_limit(3);
        pending_items.push_back(mk_item(16'hFFFF, 8'h01, 1'b0, 1'b1));
        pending_items.push_back(mk_item(5, 8'h01, 1'b1, 1'b1));
        wait_drained();
        write_limit(0);
        pending_items.push_back(mk_item(7, 8'h01, 1'b1, 1'b1));
        wait_drained();
        write_limit(8191);
        queue_random(85);
        wait_drained();

        // sender idling; nearly full store via a small limit
        write_limit(60);
        send_idle_pct = 74;
        queue_random(85);
        wait_drained();

        // receiver stalling, then a long hold-off to back up the input
        write_limit(4096);
        send_idle_pct = 0;
        recv_stall_pct = 74;
        queue_random(85);
        hold_off_cycles = 3000;
        wait_drained();

        // both idle
        write_limit(200);
        send_idle_pct = 15;
        recv_stall_pct = 15;
        queue_random(85);
        wait_drained();

        $display("Covered %0d commits (%0d refused for room) over several limits and idling",
                 n_commits, n_full);
        $display("patterns, including long text, line zero, deletes and a long output stall.");
        if (n_errors == 0 && expected_commits.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
